### design/dvru_pkg.sv
// Shared types and constants for the distance-vector route update block.
`default_nettype none

package dvru_pkg;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  localparam logic [7:0] INF_COST_RST = 8'd16;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] dest_id;
    logic [7:0] via_gateway;
    logic [7:0] hop_cost;
  } in_t;

  typedef struct packed {
    logic       was_present;
    logic       changed;
    logic [7:0] changed_cost;
    logic [7:0] entry_cost;
    logic [7:0] entry_gateway;
  } out_t;

  typedef struct packed {
    logic [7:0] cost;
    logic [7:0] gateway;
  } entry_t;

  // table write request from the rule logic
  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_t;

endpackage

`default_nettype wire

### design/distance_vector_route_update_top.sv
// Top level of the distance-vector route table with update and lookup.
//
// Usage:
//   Input: a word on in_word is taken at a rising edge with start high and
//   busy low. busy is never raised; a word may be given in every cycle.
//   opcode update applies the route rules to entry dest_id, lookup only
//   reports the entry. Destinations at or beyond HOST_COUNT are ignored.
//   Output: one result word per input word, on out_word for exactly one
//   cycle with out_strobe high. The receiver cannot stall the block.
//   Pipeline: the taken word is registered together with the RAM read, the
//   rules run on it and the result word is registered; throughput is one
//   word per cycle, set by the one read-modify-write of the route RAM per
//   cycle, with the last written entry forwarded to a following word for the same destination.
//   Configuration: cfg_we with cfg_wdata writes infinite_cost; write it
//   only while no word is in flight.
//   Reset: rst_n low clears all route valid bits at once, empties the
//   pipeline and sets infinite_cost to 16; no clearing pass is needed.
`default_nettype none

module distance_vector_route_update_top
  import dvru_pkg::*;
#(
  parameter int HOST_COUNT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_word,
  output logic            out_strobe,
  output out_t            out_word,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  localparam int DEPTH = (HOST_COUNT < 256) ? HOST_COUNT : 256;
  localparam int AW    = $clog2(DEPTH);

  logic             accept;
  logic [7:0]       inf_cost_r;
  logic             s1_vld_r;
  in_t              s1_item_r;
  logic             s1_inr_r;
  logic             prv_vld_r;
  logic [AW-1:0]    prv_idx_r;
  entry_t           prv_entry_r;
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic             out_strobe_r;
  out_t             out_word_r;

  logic [AW-1:0]    idx;
  logic             present;
  entry_t           ram_q;
  entry_t           entry;
  wr_t              wr;
  out_t             res;
  logic             we;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dvru_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wr.data),
    .raddr (in_word.dest_id[AW-1:0]),
    .rdata (ram_q)
  );

  assign idx     = s1_item_r.dest_id[AW-1:0];
  assign present = s1_inr_r && valid_r[idx];
  // the RAM read missed the previous word's write: take it from the bypass
  assign entry   = (prv_vld_r && (prv_idx_r == idx)) ? prv_entry_r : ram_q;
  assign we      = s1_vld_r && wr.en;

  dvru_rule u_rule (
    .item     (s1_item_r),
    .in_range (s1_inr_r),
    .present  (present),
    .entry    (entry),
    .inf_cost (inf_cost_r),
    .wr       (wr),
    .res      (res)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (we) begin
      valid_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_cost_r   <= INF_COST_RST;
      s1_vld_r     <= 1'b0;
      prv_vld_r    <= 1'b0;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        inf_cost_r <= cfg_wdata;
      end
      s1_vld_r     <= accept;
      prv_vld_r    <= s1_vld_r && s1_inr_r;
      valid_r      <= valid_nxt;
      out_strobe_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r   <= in_word;
    s1_inr_r    <= (32'(in_word.dest_id) < HOST_COUNT);
    prv_idx_r   <= idx;
    prv_entry_r <= wr.en ? wr.data : entry;
    out_word_r  <= res;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire

### design/dvru_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dvru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/dvru_rule.sv
// Route update rules: decides the table write and the result word for one item.
`default_nettype none

module dvru_rule
  import dvru_pkg::*;
(
  input  wire in_t        item,
  input  wire logic       in_range,
  input  wire logic       present,
  input  wire entry_t     entry,
  input  wire logic [7:0] inf_cost,
  output wr_t             wr,
  output out_t            res
);

  logic is_update;

  always_comb begin
    is_update = (item.opcode == OP_UPDATE) && in_range;
    wr        = '0;
    res       = '0;
    res.was_present = present;

    if (is_update) begin
      if (!present) begin
        wr.en           = 1'b1;
        wr.data.cost    = item.hop_cost;
        wr.data.gateway = item.via_gateway;
        res.changed     = 1'b1;
        res.changed_cost = item.hop_cost;
      end else if (item.hop_cost < entry.cost) begin
        wr.en           = 1'b1;
        wr.data.cost    = item.hop_cost;
        wr.data.gateway = item.via_gateway;
        res.changed     = 1'b1;
        res.changed_cost = item.hop_cost;
      end else if (item.via_gateway == entry.gateway) begin
        wr.en           = 1'b1;
        wr.data.cost    = item.hop_cost;
        wr.data.gateway = entry.gateway;
        res.changed     = 1'b1;
        res.changed_cost = item.hop_cost;
      end else if (item.hop_cost >= inf_cost) begin
        // broken route from another neighbour: report, keep entry
        res.changed      = 1'b1;
        res.changed_cost = entry.cost;
      end
    end

    if (wr.en) begin
      res.entry_cost    = wr.data.cost;
      res.entry_gateway = wr.data.gateway;
    end else if (present) begin
      res.entry_cost    = entry.cost;
      res.entry_gateway = entry.gateway;
    end
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the distance-vector route table: directed rows, then random phases.
module testbench;
  import dvru_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_WORDS = 100;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_word = '0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic busy;
  logic out_strobe;
  out_t out_word;

  // shadow of the route table and the infinity register
  bit       rt_valid [256];
  bit [7:0] rt_cost [256];
  bit [7:0] rt_gw [256];
  bit [7:0] inf_cost_model = INF_COST_RST;

  out_t exp_results [$];
  out_t head_result;
  int   n_err = 0;
  int   burst_left = 0;

  // reset state, infinity 16; rows with typed = 0 take the predictor's word
  row_t dir_rows [17] = '{
    '{'{OP_LOOKUP, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00}},
    '{'{OP_UPDATE, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b0, 1'b1, 8'h00, 8'h00, 8'h00}},
    '{'{OP_LOOKUP, 8'h00, 8'hff, 8'hff}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h00, 8'h00}},
    '{'{OP_UPDATE, 8'hff, 8'hff, 8'hff}, 1'b1, '{1'b0, 1'b1, 8'hff, 8'hff, 8'hff}},
    '{'{OP_UPDATE, 8'hff, 8'haa, 8'h55}, 1'b1, '{1'b1, 1'b1, 8'h55, 8'h55, 8'haa}},
    '{'{OP_UPDATE, 8'hff, 8'haa, 8'h80}, 1'b1, '{1'b1, 1'b1, 8'h80, 8'h80, 8'haa}},
    '{'{OP_UPDATE, 8'hff, 8'h55, 8'hff}, 1'b1, '{1'b1, 1'b1, 8'h80, 8'h80, 8'haa}},
    '{'{OP_UPDATE, 8'h01, 8'h01, 8'h05}, 1'b1, '{1'b0, 1'b1, 8'h05, 8'h05, 8'h01}},
    '{'{OP_UPDATE, 8'h01, 8'h02, 8'h0f}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h05, 8'h01}},
    '{'{OP_UPDATE, 8'h01, 8'h02, 8'h10}, 1'b1, '{1'b1, 1'b1, 8'h05, 8'h05, 8'h01}},
    '{'{OP_UPDATE, 8'h01, 8'h02, 8'h05}, 1'b1, '{1'b1, 1'b0, 8'h00, 8'h05, 8'h01}},
    '{'{OP_UPDATE, 8'h01, 8'h01, 8'hc8}, 1'b0, '0},
    '{'{OP_UPDATE, 8'h01, 8'h03, 8'h00}, 1'b0, '0},
    '{'{OP_LOOKUP, 8'h01, 8'hff, 8'hff}, 1'b0, '0},
    '{'{OP_LOOKUP, 8'h80, 8'hff, 8'hff}, 1'b1, '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00}},
    '{'{OP_UPDATE, 8'h80, 8'h00, 8'h10}, 1'b0, '0},
    '{'{OP_UPDATE, 8'h80, 8'h00, 8'h0f}, 1'b0, '0}
  };

  distance_vector_route_update_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // applies one accepted word to the shadow table, returns the result word
  function automatic out_t route_update(in_t w);
    out_t     r;
    bit [7:0] d;
    r = '0;
    d = w.dest_id;
    r.was_present = rt_valid[d];
    if (w.opcode == OP_UPDATE) begin
      if (!rt_valid[d]) begin
        rt_valid[d] = 1'b1;
        rt_cost[d] = w.hop_cost;
        rt_gw[d] = w.via_gateway;
        r.changed = 1'b1;
        r.changed_cost = w.hop_cost;
      end else if (w.hop_cost < rt_cost[d]) begin
        rt_cost[d] = w.hop_cost;
        rt_gw[d] = w.via_gateway;
        r.changed = 1'b1;
        r.changed_cost = w.hop_cost;
      end else if (w.via_gateway == rt_gw[d]) begin
        rt_cost[d] = w.hop_cost;
        r.changed = 1'b1;
        r.changed_cost = w.hop_cost;
      end else if (w.hop_cost >= inf_cost_model) begin
        // broken route from another neighbour: stored cost goes out
        r.changed = 1'b1;
        r.changed_cost = rt_cost[d];
      end
    end
    if (rt_valid[d]) begin
      r.entry_cost = rt_cost[d];
      r.entry_gateway = rt_gw[d];
    end
    return r;
  endfunction

  // drives one word after a random gap and waits for it to be taken
  task automatic send_word(input in_t w, output bit taken);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(5, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    taken = 1'b1;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_infinity(input bit [7:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    inf_cost_model = v;
  endtask

  task automatic run_phase(input int count);
    in_t w;
    int  c;
    bit  taken;
    for (int i = 0; i < count; i++) begin
      w.opcode = ($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_UPDATE;
      case ($urandom_range(0, 9))
        0, 1:    w.dest_id = 8'($urandom_range(0, 255));
        2:       w.dest_id = 8'($urandom_range(240, 255));
        default: w.dest_id = 8'($urandom_range(0, 15));
      endcase
      w.via_gateway = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3))
                                                 : 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: w.hop_cost = 8'($urandom_range(0, 255));
        1: begin
          // straddle the infinity threshold
          c = int'(inf_cost_model) + $urandom_range(0, 4) - 2;
          w.hop_cost = (c < 0) ? 8'd0 : (c > 255) ? 8'd255 : c[7:0];
        end
        default: w.hop_cost = 8'($urandom_range(0, 20));
      endcase
      send_word(w, taken);
      exp_results.push_back(route_update(w));
    end
  endtask

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    n_err++;
    if (n_err <= 10)
      $display({"mismatch (%s): exp pres %0d chg %0d ccost %0d cost %0d gw %0d,",
                " got pres %0d chg %0d ccost %0d cost %0d gw %0d"},
               what, want.was_present, want.changed, want.changed_cost, want.entry_cost,
               want.entry_gateway, got.was_present, got.changed, got.changed_cost,
               got.entry_cost, got.entry_gateway);
  endtask

  // results cannot be held off: every strobe is checked as it comes
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (exp_results.size() == 0) begin
        report_mismatch("no word expected", '0, out_word);
      end else begin
        head_result = exp_results.pop_front();
        if (out_word.was_present !== head_result.was_present ||
            out_word.changed !== head_result.changed ||
            out_word.changed_cost !== head_result.changed_cost ||
            out_word.entry_cost !== head_result.entry_cost ||
            out_word.entry_gateway !== head_result.entry_gateway)
          report_mismatch("field", head_result, out_word);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    out_t pred;
    bit   taken;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word, taken);
      pred = route_update(dir_rows[i].word);
      exp_results.push_back(dir_rows[i].typed ? dir_rows[i].res : pred);
    end
    run_phase(PHASE_WORDS);

    set_infinity(8'd255);
    run_phase(PHASE_WORDS);
    // zero: every cost counts as broken
    set_infinity(8'd0);
    run_phase(PHASE_WORDS);
    set_infinity(8'd1);
    run_phase(PHASE_WORDS);
    set_infinity(8'($urandom_range(2, 254)));
    run_phase(PHASE_WORDS);
    set_infinity(INF_COST_RST);
    run_phase(PHASE_WORDS);

    wait_idle();
    if (n_err == 0 && exp_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
